### rtl/rws_pkg.sv
package rws_pkg;

  // field widths of the stream items and the register
  localparam int unsigned CMD_W    = 1;
  localparam int unsigned SLOT_W   = 8;
  localparam int unsigned FIT_W    = 32;
  localparam int unsigned TICKET_W = 14;
  localparam int unsigned POP_W    = 9;
  localparam int unsigned TOTAL_W  = 40;

  // packed stream layout
  localparam int unsigned IN_DATA_W  = 56;
  localparam int unsigned OUT_DATA_W = 16;

  // full scale of a ticket, also the scale of the cumulative fitness
  localparam logic [TICKET_W-1:0] TICKET_FULL = 14'd10000;

  // population size after reset
  localparam logic [POP_W-1:0] POP_RESET = 9'd256;

  // item kinds carried in tuser
  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD = 1'b0,
    CMD_DRAW = 1'b1
  } cmd_e;

  // sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LD_WR,
    ST_D_SETUP,
    ST_D_RUN,
    ST_D_OUT
  } state_e;

  // control from the sequencer to the scan unit
  typedef struct packed {
    logic init;   // start of a draw: latch border, clear accumulators
    logic valid;  // memory read data holds one slot's fitness
    logic last;   // that slot is the last one in use
  } scan_ctrl_t;

endpackage

### rtl/rws_scan.sv
module rws_scan import rws_pkg::*; #(
  parameter int unsigned IDX_W = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  scan_ctrl_t          ctrl_i,
  input  logic [TOTAL_W-1:0]  total_i,
  input  logic [TICKET_W-1:0] ticket_i,
  input  logic [IDX_W-1:0]    last_slot_i,
  input  logic [IDX_W-1:0]    idx_i,
  input  logic [FIT_W-1:0]    fit_i,
  output logic [IDX_W-1:0]    pick_o,
  output logic [IDX_W-1:0]    best_o,
  output logic                done_o
);

  localparam int unsigned PROD_W = FIT_W + TICKET_W;
  localparam int unsigned CUM_W  = PROD_W + IDX_W;
  localparam int unsigned BRD_W  = TOTAL_W + TICKET_W;
  localparam int unsigned CMP_W  = (CUM_W > BRD_W) ? CUM_W : BRD_W;

  logic [BRD_W-1:0]  border_q;
  logic              mv_q, ml_q;
  logic [PROD_W-1:0] prod_q;
  logic [FIT_W-1:0]  mf_q;
  logic [IDX_W-1:0]  midx_q;
  logic [CUM_W-1:0]  cum_q, cum_d;
  logic              found_q;
  logic [IDX_W-1:0]  pick_q, best_q;
  logic [FIT_W-1:0]  bval_q;
  logic              hit;

  // border = total * ticket, set once per draw
  always_ff @(posedge clk_i) begin
    if (ctrl_i.init) begin
      border_q <= BRD_W'(total_i) * BRD_W'(ticket_i);
    end
  end

  // scale stage: fitness times full ticket
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_q <= 1'b0;
      ml_q <= 1'b0;
    end else begin
      mv_q <= ctrl_i.valid;
      ml_q <= ctrl_i.valid & ctrl_i.last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.valid) begin
      prod_q <= PROD_W'(fit_i) * PROD_W'(TICKET_FULL);
      mf_q   <= fit_i;
      midx_q <= idx_i;
    end
  end

  // running scaled sum and border compare
  assign cum_d = cum_q + CUM_W'(prod_q);
  assign hit   = !found_q && (CMP_W'(cum_d) >= CMP_W'(border_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (ctrl_i.init) begin
      found_q <= 1'b0;
    end else if (mv_q && hit) begin
      found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.init) begin
      cum_q  <= '0;
      pick_q <= last_slot_i;
      best_q <= '0;
      bval_q <= '0;
    end else if (mv_q) begin
      cum_q <= cum_d;
      if (hit) begin
        pick_q <= midx_q;
      end
      // first maximum wins: strict compare
      if (mf_q > bval_q) begin
        best_q <= midx_q;
        bval_q <= mf_q;
      end
    end
  end

  assign pick_o = pick_q;
  assign best_o = best_q;
  assign done_o = mv_q & ml_q;

endmodule

### rtl/roulette_wheel_selection_unit.sv
// Fitness-proportionate (roulette wheel) selection table. A load transfer
// (tuser = 0) writes one slot's unsigned 16.16 fitness and updates a 40-bit
// running total; it reads the old value, then writes the new one, and gives
// no result; a load to a slot outside the population is dropped. A draw
// transfer (tuser = 1) carries a ticket 0..10000 (larger values saturate)
// and returns the first slot whose cumulative fitness times 10000 reaches
// total times ticket, clamped to the last slot in use, plus the first slot
// holding the greatest fitness. A draw walks the fitness memory through its
// single read port, one slot per cycle. One item is worked on at a time;
// a finished result waits in an output register while the next item is
// taken. After reset a clearing pass zeroes the memory, one entry per
// cycle; no item is taken during it, while population size writes are
// taken at any time.
module roulette_wheel_selection_unit import rws_pkg::*; #(
  parameter int unsigned MAX_POPULATION = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration: population size
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [POP_W-1:0]      cfg_data_i,
  // input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // slot[7:0], fitness[39:8], ticket[53:40], zero[55:54]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // cmd[0]
  input  logic [CMD_W-1:0]      s_axis_tuser,
  // result stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // picked_slot[7:0], best_slot[15:8]
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  localparam int unsigned IDX_W = (MAX_POPULATION > 1) ? $clog2(MAX_POPULATION) : 1;
  localparam int unsigned N_W   = IDX_W + 1;

  state_e state_q, state_d;

  // input fields
  logic [SLOT_W-1:0]   in_slot;
  logic [FIT_W-1:0]    in_fit;
  logic [TICKET_W-1:0] in_ticket;
  logic                in_xfer;
  logic                slot_ok;

  assign in_slot   = s_axis_tdata[SLOT_W-1:0];
  assign in_fit    = s_axis_tdata[SLOT_W+FIT_W-1:SLOT_W];
  assign in_ticket = s_axis_tdata[SLOT_W+FIT_W+TICKET_W-1:SLOT_W+FIT_W];
  assign in_xfer   = s_axis_tvalid & s_axis_tready;

  // registers
  logic [POP_W-1:0]    pop_q;
  logic [N_W-1:0]      n;
  logic [TOTAL_W-1:0]  total_q;
  logic [IDX_W-1:0]    slot_q;
  logic [FIT_W-1:0]    fit_q;
  logic [TICKET_W-1:0] ticket_q;
  logic [IDX_W-1:0]    clr_idx_q;
  logic [N_W-1:0]      rd_idx_q;
  logic                rd_v_q, rd_last_q;
  logic [IDX_W-1:0]    rd_slot_q;
  logic                m_valid_q;
  logic [OUT_DATA_W-1:0] m_data_q;

  // fitness memory
  logic [FIT_W-1:0] mem [MAX_POPULATION];
  logic             mem_we, mem_re;
  logic [IDX_W-1:0] mem_waddr, mem_raddr;
  logic [FIT_W-1:0] mem_wdata, mem_rdata_q;

  // sequencer outputs
  logic       clr_last;
  logic       rd_issue;
  logic       out_load;
  scan_ctrl_t scan_ctrl;
  logic [IDX_W-1:0] scan_pick, scan_best;
  logic       scan_done;

  // slots in use, clamped to 1..MAX_POPULATION
  always_comb begin
    if (pop_q == '0) begin
      n = N_W'(1);
    end else if (32'(pop_q) > MAX_POPULATION) begin
      n = N_W'(MAX_POPULATION);
    end else begin
      n = N_W'(pop_q);
    end
  end

  assign slot_ok  = 32'(in_slot) < 32'(n);
  assign clr_last = (clr_idx_q == IDX_W'(MAX_POPULATION - 1));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_xfer) begin
          if (s_axis_tuser == CMD_DRAW) begin
            state_d = ST_D_SETUP;
          end else if (slot_ok) begin
            state_d = ST_LD_WR;
          end
        end
      end
      ST_LD_WR:   state_d = ST_IDLE;
      ST_D_SETUP: state_d = ST_D_RUN;
      ST_D_RUN: begin
        if (scan_done) state_d = ST_D_OUT;
      end
      ST_D_OUT: begin
        if (!m_valid_q || m_axis_tready) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_axis_tready   = 1'b0;
    mem_we          = 1'b0;
    mem_waddr       = slot_q;
    mem_wdata       = fit_q;
    mem_re          = 1'b0;
    mem_raddr       = rd_idx_q[IDX_W-1:0];
    rd_issue        = 1'b0;
    out_load        = 1'b0;
    scan_ctrl.init  = 1'b0;
    scan_ctrl.valid = rd_v_q;
    scan_ctrl.last  = rd_last_q;
    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_idx_q;
        mem_wdata = '0;
      end
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        // read the old value for a load
        mem_re    = in_xfer && (s_axis_tuser == CMD_LOAD) && slot_ok;
        mem_raddr = IDX_W'(in_slot);
      end
      ST_LD_WR: begin
        mem_we = 1'b1;
      end
      ST_D_SETUP: begin
        scan_ctrl.init = 1'b1;
      end
      ST_D_RUN: begin
        rd_issue = (rd_idx_q < n);
        mem_re   = rd_issue;
      end
      ST_D_OUT: begin
        out_load = !m_valid_q || m_axis_tready;
      end
      default: begin
      end
    endcase
  end

  // memory ports
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= mem[mem_raddr];
    end
  end

  // state and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      pop_q     <= POP_RESET;
      total_q   <= '0;
      clr_idx_q <= '0;
      rd_idx_q  <= '0;
      rd_v_q    <= 1'b0;
      rd_last_q <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        pop_q <= cfg_data_i;
      end
      if (state_q == ST_CLEAR) begin
        clr_idx_q <= clr_idx_q + IDX_W'(1);
      end
      // replace the old value in the running total
      if (state_q == ST_LD_WR) begin
        total_q <= total_q - TOTAL_W'(mem_rdata_q) + TOTAL_W'(fit_q);
      end
      if (state_q == ST_D_SETUP) begin
        rd_idx_q <= '0;
      end else if (rd_issue) begin
        rd_idx_q <= rd_idx_q + N_W'(1);
      end
      rd_v_q    <= rd_issue;
      rd_last_q <= rd_issue && (rd_idx_q == n - N_W'(1));
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      slot_q   <= IDX_W'(in_slot);
      fit_q    <= in_fit;
      ticket_q <= (in_ticket > TICKET_FULL) ? TICKET_FULL : in_ticket;
    end
    if (rd_issue) begin
      rd_slot_q <= rd_idx_q[IDX_W-1:0];
    end
    if (out_load) begin
      m_data_q <= {SLOT_W'(scan_best), SLOT_W'(scan_pick)};
    end
  end

  // cumulative compare and elite search
  rws_scan #(
    .IDX_W (IDX_W)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (scan_ctrl),
    .total_i     (total_q),
    .ticket_i    (ticket_q),
    .last_slot_i (IDX_W'(n - N_W'(1))),
    .idx_i       (rd_slot_q),
    .fit_i       (mem_rdata_q),
    .pick_o      (scan_pick),
    .best_o      (scan_best),
    .done_o      (scan_done)
  );

  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

`ifndef SYNTHESIS
  // memory is written only by the clearing pass or the load write state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == ST_CLEAR || state_q == ST_LD_WR))
    else $error("fitness memory written outside clear or load");

  // a pending result is never overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!m_valid_q || m_axis_tready))
    else $error("result register overwritten while pending");

  // the scan finishes only while a draw walks the memory
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_done |-> (state_q == ST_D_RUN && !rd_issue))
    else $error("scan done outside draw walk");

  // reads stay within the slots in use
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_issue |=> (rd_idx_q <= n))
    else $error("draw read past the population");
`endif

endmodule

### sim/roulette_wheel_selection_unit_test.sv
module roulette_wheel_selection_unit_test;
  import rws_pkg::*;

  localparam int unsigned MAX_POP        = 256;
  localparam int unsigned HOLD_CYCLES    = 600;
  localparam int unsigned LOAD_SETTLE    = 8;
  localparam int unsigned DRAIN_CYCLES   = 300;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned MAX_REPORTS    = 10;
  localparam int unsigned PAD_W          = IN_DATA_W - SLOT_W - FIT_W - TICKET_W;

  // population settings per phase, with the number of effective items in each
  localparam int unsigned N_PHASES       = 10;
  localparam int unsigned PRESSURE_PHASE = 7;
  localparam int unsigned PHASE_POP   [N_PHASES] = '{256, 1, 2, 0, 16, 511, 300, 5, 64, 256};
  localparam int unsigned PHASE_ITEMS [N_PHASES] = '{90, 60, 80, 40, 120, 70, 40, 130, 130, 90};

  typedef struct packed {
    logic [SLOT_W-1:0] best;
    logic [SLOT_W-1:0] pick;
  } spin_t;

  typedef struct packed {
    cmd_e                cmd;
    logic [SLOT_W-1:0]   slot;
    logic [FIT_W-1:0]    fit;
    logic [TICKET_W-1:0] ticket;
    logic                typed;  // expected pick and best given in the row
    logic [SLOT_W-1:0]   pick;
    logic [SLOT_W-1:0]   best;
  } dir_row_t;

  localparam int unsigned DIR_N = 24;

  // directed rows, starting from the cleared table with all slots in use
  dir_row_t dir_rows [DIR_N] = '{
    '{CMD_DRAW, 8'd0,   32'h0000_0000, 14'd0,     1'b1, 8'd0,   8'd0},
    '{CMD_DRAW, 8'd0,   32'h0000_0000, 14'd10000, 1'b1, 8'd0,   8'd0},
    '{CMD_DRAW, 8'd0,   32'h0000_0000, 14'd16383, 1'b1, 8'd0,   8'd0},
    '{CMD_LOAD, 8'd0,   32'hFFFF_FFFF, 14'd0,     1'b0, 8'd0,   8'd0},
    '{CMD_LOAD, 8'd255, 32'hFFFF_FFFF, 14'd0,     1'b0, 8'd0,   8'd0},
    '{CMD_DRAW, 8'd0,   32'h0000_0000, 14'd0,     1'b1, 8'd0,   8'd0},
    '{CMD_DRAW, 8'd0,   32'h0000_0000, 14'd5000,  1'b1, 8'd0,   8'd0},
    '{CMD_DRAW, 8'd0,   32'h0000_0000, 14'd5001,  1'b1, 8'd255, 8'd0},
    '{CMD_DRAW, 8'd0,   32'h0000_0000, 14'd10000, 1'b1, 8'd255, 8'd0},
    '{CMD_LOAD, 8'd255, 32'h0000_0000, 14'd0,     1'b0, 8'd0,   8'd0},
    '{CMD_DRAW, 8'd0,   32'h0000_0000, 14'd10000, 1'b1, 8'd0,   8'd0},
    '{CMD_LOAD, 8'd128, 32'h0001_0000, 14'd0,     1'b0, 8'd0,   8'd0},
    '{CMD_LOAD, 8'd3,   32'h0000_0001, 14'd0,     1'b0, 8'd0,   8'd0},
    '{CMD_LOAD, 8'd200, 32'hFFFF_FFFF, 14'd0,     1'b0, 8'd0,   8'd0},
    '{CMD_DRAW, 8'd0,   32'h0000_0000, 14'd16383, 1'b0, 8'd0,   8'd0},
    '{CMD_DRAW, 8'd0,   32'h0000_0000, 14'd1,     1'b0, 8'd0,   8'd0},
    '{CMD_DRAW, 8'd0,   32'h0000_0000, 14'd9999,  1'b0, 8'd0,   8'd0},
    '{CMD_LOAD, 8'd0,   32'h0000_0000, 14'd0,     1'b0, 8'd0,   8'd0},
    '{CMD_DRAW, 8'd0,   32'h0000_0000, 14'd5000,  1'b0, 8'd0,   8'd0},
    '{CMD_LOAD, 8'd255, 32'hAAAA_AAAA, 14'd0,     1'b0, 8'd0,   8'd0},
    '{CMD_LOAD, 8'd254, 32'h5555_5555, 14'd0,     1'b0, 8'd0,   8'd0},
    '{CMD_DRAW, 8'd0,   32'h0000_0000, 14'd3333,  1'b0, 8'd0,   8'd0},
    '{CMD_DRAW, 8'd0,   32'h0000_0000, 14'd10000, 1'b0, 8'd0,   8'd0},
    '{CMD_DRAW, 8'd0,   32'h0000_0000, 14'd8191,  1'b0, 8'd0,   8'd0}
  };

  // block ports
  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [POP_W-1:0]      cfg_data_i    = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic [CMD_W-1:0]      s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  // mirror of the fitness table
  logic [FIT_W-1:0]   fit_table [MAX_POP];
  logic [TOTAL_W-1:0] fit_sum   = '0;
  logic [POP_W-1:0]   pop_size  = POP_RESET;

  spin_t       spin_q [$];
  int unsigned err_count    = 0;
  int unsigned idle_cycles  = 0;
  int unsigned n_loads      = 0;
  int unsigned n_ignored    = 0;
  int unsigned n_draws      = 0;
  int unsigned n_results    = 0;
  int unsigned n_cfg        = 0;
  bit          src_idle_on  = 1'b1;
  bit          snk_idle_on  = 1'b1;
  bit          hold_off_req = 1'b0;
  bit          hold_off_done = 1'b0;

  roulette_wheel_selection_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    for (int i = 0; i < MAX_POP; i++) fit_table[i] = '0;
  end

  // slots in use, out-of-range sizes clamped
  function automatic int unsigned active_slots();
    if (pop_size == 0) return 1;
    if (pop_size > MAX_POP) return MAX_POP;
    return 32'(pop_size);
  endfunction

  // load one slot, keeping the running total; false when the slot is not in use
  function automatic bit table_load(logic [SLOT_W-1:0] slot, logic [FIT_W-1:0] fit);
    if (slot >= active_slots()) return 1'b0;
    fit_sum = fit_sum - TOTAL_W'(fit_table[slot]) + TOTAL_W'(fit);
    fit_table[slot] = fit;
    return 1'b1;
  endfunction

  // roulette pick and elite slot for one ticket
  function automatic spin_t wheel_spin(logic [TICKET_W-1:0] ticket);
    logic [63:0]  border;
    logic [63:0]  cum;
    logic [63:0]  tkt;
    int unsigned  n;
    int unsigned  pick;
    int unsigned  best;
    bit           found;
    spin_t        r;
    n     = active_slots();
    tkt   = (ticket > TICKET_FULL) ? 64'(TICKET_FULL) : 64'(ticket);
    border = 64'(fit_sum) * tkt;
    cum   = '0;
    pick  = n - 1;
    best  = 0;
    found = 1'b0;
    for (int i = 0; i < n; i++) begin
      cum = cum + 64'(fit_table[i]);
      if (!found && cum * 64'(TICKET_FULL) >= border) begin
        pick  = i;
        found = 1'b1;
      end
      if (fit_table[i] > fit_table[best]) best = i;
    end
    r.pick = SLOT_W'(pick);
    r.best = SLOT_W'(best);
    return r;
  endfunction

  function automatic void note_error(string msg);
    err_count++;
    if (err_count <= MAX_REPORTS) $display("mismatch: %s", msg);
  endfunction

  // idle length, mostly short with a few long stretches
  function automatic int unsigned idle_gap(bit on);
    int unsigned r;
    if (!on) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [FIT_W-1:0] rand_fitness();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return $urandom;
      5, 6, 7: return $urandom_range(0, 32'h0003_0000);
      default: return $urandom >> $urandom_range(0, 31);
    endcase
  endfunction

  function automatic logic [TICKET_W-1:0] rand_ticket();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return TICKET_FULL;
      2:       return TICKET_W'($urandom_range(10001, 16383));
      default: return TICKET_W'($urandom_range(0, 10000));
    endcase
  endfunction

  // offer one item and return at the edge of its transfer
  task automatic send_item(cmd_e c, logic [SLOT_W-1:0] s, logic [FIT_W-1:0] f,
                           logic [TICKET_W-1:0] t);
    int unsigned gap;
    gap = idle_gap(src_idle_on);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{PAD_W{1'b0}}, t, f, s};
    s_axis_tuser  <= c;
    do @(negedge clk_i); while (!s_axis_tready);
    @(posedge clk_i);
  endtask

  task automatic write_population(logic [POP_W-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(negedge clk_i); while (!cfg_ready_o);
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    pop_size = v;
    n_cfg++;
  endtask

  // stimulus: directed table, then random phases at several population sizes
  initial begin : stimulus
    cmd_e                c;
    logic [SLOT_W-1:0]   slot;
    logic [FIT_W-1:0]    fit;
    logic [TICKET_W-1:0] tkt;
    spin_t               want;
    int unsigned         done;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int k = 0; k < DIR_N; k++) begin
      send_item(dir_rows[k].cmd, dir_rows[k].slot, dir_rows[k].fit, dir_rows[k].ticket);
      if (dir_rows[k].cmd == CMD_LOAD) begin
        n_loads++;
        if (!table_load(dir_rows[k].slot, dir_rows[k].fit)) n_ignored++;
      end else begin
        n_draws++;
        want = wheel_spin(dir_rows[k].ticket);
        if (dir_rows[k].typed) begin
          want.pick = dir_rows[k].pick;
          want.best = dir_rows[k].best;
        end
        spin_q.push_back(want);
      end
    end

    for (int p = 0; p < N_PHASES; p++) begin
      // size changes only with the block drained
      s_axis_tvalid <= 1'b0;
      while (spin_q.size() != 0) @(posedge clk_i);
      repeat (LOAD_SETTLE) @(posedge clk_i);
      write_population(POP_W'(PHASE_POP[p]));
      src_idle_on = ($urandom_range(0, 3) != 0);
      snk_idle_on = ($urandom_range(0, 3) != 0);
      if (p == PRESSURE_PHASE) hold_off_req = 1'b1;
      done = 0;
      while (done < PHASE_ITEMS[p]) begin
        c    = ($urandom_range(0, 9) < 4) ? CMD_DRAW : CMD_LOAD;
        slot = ($urandom_range(0, 99) < 85) ? SLOT_W'($urandom_range(0, active_slots() - 1))
                                             : SLOT_W'($urandom_range(0, 255));
        fit  = (c == CMD_LOAD) ? rand_fitness() : FIT_W'($urandom);
        tkt  = (c == CMD_DRAW) ? rand_ticket() : TICKET_W'($urandom);
        send_item(c, slot, fit, tkt);
        if (c == CMD_LOAD) begin
          n_loads++;
          if (table_load(slot, fit)) done++;
          else n_ignored++;
        end else begin
          n_draws++;
          spin_q.push_back(wheel_spin(tkt));
          done++;
        end
      end
    end

    s_axis_tvalid <= 1'b0;
    while (spin_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("run covered %0d loads (%0d outside the population), %0d draws, %0d picks checked",
             n_loads, n_ignored, n_draws, n_results);
    $display("%0d population sizes set, clamped ones and a long receiver stall included",
             n_cfg);
    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches in total", err_count);
      $display("*** FAILED ***");
    end
    $finish;
  end

  // result side: random stalls, one long hold-off, and the field compare
  initial begin : result_sink
    int unsigned gap;
    spin_t       want;
    spin_t       got;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_off_req && !hold_off_done) begin
        gap = HOLD_CYCLES;
        hold_off_done = 1'b1;
      end else begin
        gap = idle_gap(snk_idle_on);
      end
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(negedge clk_i); while (m_axis_tvalid !== 1'b1);
      got = m_axis_tdata;
      n_results++;
      if (spin_q.size() == 0) begin
        note_error($sformatf("result with nothing pending: pick %0d best %0d",
                             got.pick, got.best));
      end else begin
        want = spin_q.pop_front();
        if (got.pick !== want.pick)
          note_error($sformatf("picked_slot expected %0d actual %0d", want.pick, got.pick));
        if (got.best !== want.best)
          note_error($sformatf("best_slot expected %0d actual %0d", want.best, got.best));
      end
      @(posedge clk_i);
    end
  end

  // watchdog on cycles without any transfer
  always @(negedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles = 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d cycles without a transfer", idle_cycles);
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles = idle_cycles + 1;
    end
  end

endmodule
